>>> sv/tupe_pkg.sv
// Shared types, codes and defaults for the trie unique prefix engine.
`timescale 1ns / 1ps

package tupe_pkg;

    // Default sizes of the trie.
    localparam int NODE_COUNT_DEF   = 1024;
    localparam int ALPHABET_DEF     = 26;
    localparam int MAX_WORD_LEN_DEF = 63;

    // Field widths on the stream ports.
    localparam int OPCODE_W = 2;
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 3;
    localparam int PREFIX_W = 6;

    // Operation codes carried in the input user field.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_UNIQUE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

    // Word error register value when the current word has no error yet.
    localparam logic [STATUS_W-1:0] ERR_NONE = 3'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the input item and read the cursor row
        logic exec;       // apply the latched letter to the row just read
        logic clear_ctx;  // empty the trie context and post the cleared result
        logic sweep_wr;   // write one zero row during the clearing sweep
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_last;  // latched letter ends its word
        logic out_busy;   // output register holds a result not taken this cycle
        logic sweep_last; // clearing sweep is at its final row
    } stat_t;

endpackage

>>> sv/tupe_ctrl.sv
// Controller state machine: item acceptance, letter execution and clearing sweep.
`timescale 1ns / 1ps

module tupe_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    input  logic [tupe_pkg::OPCODE_W-1:0] in_opcode,
    output logic                          s_ready,
    input  tupe_pkg::stat_t               stat,
    output tupe_pkg::cmd_t                cmd
);
    import tupe_pkg::*;

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       take;

    assign s_ready = (state_reg == S_IDLE);
    assign take    = s_valid && s_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.accept    = take;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_opcode inside {OP_INSERT, OP_QUERY})
                    begin
                        state_next = S_EXEC;
                    end
                    else if (in_opcode == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_EXEC:
            begin
                // A word-ending letter waits until the output register is free.
                if (!(stat.item_last && stat.out_busy))
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (!stat.out_busy)
                begin
                    cmd.clear_ctx = 1'b1;
                    state_next    = S_SWEEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/tupe_datapath.sv
// Datapath: trie row memory, word context, node allocator and result register.
`timescale 1ns / 1ps

module tupe_datapath #(
    parameter int NODE_COUNT   = tupe_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET     = tupe_pkg::ALPHABET_DEF,
    parameter int MAX_WORD_LEN = tupe_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tupe_pkg::cmd_t                cmd,
    output tupe_pkg::stat_t               stat,
    input  logic [tupe_pkg::OPCODE_W-1:0] in_opcode,
    input  logic [tupe_pkg::LETTER_W-1:0] in_letter,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tupe_pkg::STATUS_W-1:0] out_status,
    output logic [tupe_pkg::PREFIX_W-1:0] out_prefix
);
    import tupe_pkg::*;

    localparam int NB = $clog2(NODE_COUNT);
    localparam int LB = $clog2(ALPHABET);
    localparam int PB = $clog2(MAX_WORD_LEN + 1);
    localparam int EW = NB + 2;
    localparam int RW = ALPHABET * EW;
    localparam int LETTER_CODES = 2 ** LETTER_W;

    // Letters are folded into the alphabet by a constant table.
    logic [LB-1:0] letter_map [LETTER_CODES];
    for (genvar i = 0; i < LETTER_CODES; i++)
    begin : g_letter_map
        assign letter_map[i] = LB'(i % ALPHABET);
    end

    // Latched item.
    logic [OPCODE_W-1:0] op_reg;
    logic [LB-1:0]       letter_reg;
    logic                last_reg;

    // Trie memory: one row of edges per node, each edge {count, child}.
    logic [RW-1:0] mem [NODE_COUNT];
    logic [RW-1:0] rd_row_reg;
    logic [RW-1:0] row_mod;
    logic [RW-1:0] wr_row;
    logic [NB-1:0] wr_addr;
    logic          wr_en;
    logic          row_wr;

    // Word context and allocator.
    logic [NB-1:0]       cursor_reg, cursor_next;
    logic [PB-1:0]       pos_reg, pos_next;
    logic [PB-1:0]       found_reg, found_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [NB-1:0]       free_reg, free_next;
    logic [NB-1:0]       sweep_reg, sweep_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic                load_out;

    logic [EW-1:0]       entry;
    logic [EW-1:0]       entry_new;
    logic [NB-1:0]       child;
    logic [1:0]          count;
    logic [STATUS_W-1:0] word_status;
    logic [PB+PREFIX_W-1:0] found_wide;

    assign entry = rd_row_reg[letter_reg*EW +: EW];
    assign child = entry[NB-1:0];
    assign count = entry[EW-1:NB];

    always_comb
    begin
        cursor_next = cursor_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        err_next    = err_reg;
        free_next   = free_reg;
        entry_new   = entry;
        row_wr      = 1'b0;
        load_out    = 1'b0;
        status_next = status_reg;
        prefix_next = prefix_reg;
        word_status = ST_INSERTED;
        found_wide  = '0;

        if (cmd.exec)
        begin
            if (err_reg == ERR_NONE)
            begin
                if (pos_reg >= PB'(MAX_WORD_LEN))
                begin
                    err_next = ST_TOO_LONG;
                end
                else
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (child == '0)
                        begin
                            if (free_reg == NB'(NODE_COUNT - 1))
                            begin
                                err_next = ST_FULL;
                            end
                            else
                            begin
                                free_next   = free_reg + 1'b1;
                                entry_new   = {2'd1, free_next};
                                row_wr      = 1'b1;
                                cursor_next = free_next;
                            end
                        end
                        else
                        begin
                            // Edge counts saturate at two.
                            if (count < 2'd2)
                            begin
                                entry_new = {count + 2'd1, child};
                                row_wr    = 1'b1;
                            end
                            cursor_next = child;
                        end
                    end
                    else if (found_reg == '0)
                    begin
                        if (child == '0)
                        begin
                            err_next = ST_ABSENT;
                        end
                        else if (count == 2'd1)
                        begin
                            found_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            cursor_next = child;
                        end
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end

            if (last_reg)
            begin
                if (err_next != ERR_NONE)
                begin
                    word_status = err_next;
                end
                else if (op_reg == OP_INSERT)
                begin
                    word_status = ST_INSERTED;
                end
                else if (found_next != '0)
                begin
                    word_status = ST_FOUND;
                end
                else
                begin
                    word_status = ST_NO_UNIQUE;
                end
                found_wide  = {{PREFIX_W{1'b0}}, found_next};
                load_out    = 1'b1;
                status_next = word_status;
                prefix_next = (word_status == ST_FOUND) ? found_wide[PREFIX_W-1:0] : '0;
                cursor_next = '0;
                pos_next    = '0;
                found_next  = '0;
                err_next    = ERR_NONE;
            end
        end

        if (cmd.clear_ctx)
        begin
            cursor_next = '0;
            pos_next    = '0;
            found_next  = '0;
            err_next    = ERR_NONE;
            free_next   = '0;
            load_out    = 1'b1;
            status_next = ST_CLEARED;
            prefix_next = '0;
        end
    end

    always_comb
    begin
        row_mod = rd_row_reg;
        row_mod[letter_reg*EW +: EW] = entry_new;
    end

    assign wr_en   = row_wr || cmd.sweep_wr;
    assign wr_addr = cmd.sweep_wr ? sweep_reg : cursor_reg;
    assign wr_row  = cmd.sweep_wr ? '0 : row_mod;

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.clear_ctx)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_next = stat.sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (cmd.accept)
        begin
            rd_row_reg <= mem[cursor_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= in_opcode;
            letter_reg <= letter_map[in_letter];
            last_reg   <= in_last;
        end
        status_reg <= status_next;
        prefix_reg <= prefix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            pos_reg       <= '0;
            found_reg     <= '0;
            err_reg       <= ERR_NONE;
            free_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            err_reg       <= err_next;
            free_reg      <= free_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.item_last  = last_reg;
    assign stat.out_busy   = out_valid_reg && !out_ready;
    assign stat.sweep_last = (sweep_reg == NB'(NODE_COUNT - 1));

    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_prefix = prefix_reg;

endmodule

>>> sv/trie_unique_prefix_engine.sv
// Top level of the trie unique prefix engine: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Channel      Direction  Payload
// s_axis_*     in         tuser = opcode, tdata = letter, tlast = word_end
// m_axis_*     out        tuser = status, tdata = prefix_length
//
// Each insert or query letter is handled before the next item is taken: the
// transfer cycle reads the trie row of the cursor node from the single-port row
// memory, then the execute state updates the edge, writes the row back for an
// insert and moves the cursor. After reset and after every clear command, the
// block sweeps zeros through all NODE_COUNT rows and takes no input meanwhile.
// A word-ending letter or a clear waits while the previous result has not
// been taken; letters that produce no result never wait on the output side.

module trie_unique_prefix_engine #(
    parameter int NODE_COUNT   = tupe_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET     = tupe_pkg::ALPHABET_DEF,
    parameter int MAX_WORD_LEN = tupe_pkg::MAX_WORD_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] opcode
    input  logic       s_axis_tlast,   // word_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] prefix_length, [7:6] zero
    output logic [2:0] m_axis_tuser    // [2:0] status
);
    import tupe_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] out_status;
    logic [PREFIX_W-1:0] out_prefix;

    // The controller sequences each transfer; the datapath holds all trie state.
    tupe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .s_ready   (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tupe_datapath #(
        .NODE_COUNT   (NODE_COUNT),
        .ALPHABET     (ALPHABET),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_opcode  (s_axis_tuser),
        .in_letter  (s_axis_tdata[LETTER_W-1:0]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .out_prefix (out_prefix)
    );

    // The result payload is packed from the lowest bit, padded to whole bytes.
    assign m_axis_tdata = {{(8 - PREFIX_W){1'b0}}, out_prefix};
    assign m_axis_tuser = out_status;

endmodule

>>> test/trie_unique_prefix_engine_tb.sv
// Self-checking testbench for the trie unique prefix engine, with its own trie predictor.
`timescale 1ns / 1ps

module trie_unique_prefix_engine_tb;
    import tupe_pkg::*;

    localparam int NODES        = NODE_COUNT_DEF;
    localparam int ALPH         = ALPHABET_DEF;
    localparam int MAXLEN       = MAX_WORD_LEN_DEF;
    localparam int SLOTS        = NODES * ALPH;
    localparam int BANK_SIZE    = 512;
    localparam int WORD_MAX     = 72;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 150;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int RUN_LIMIT_NS = 4000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PREFIX_W-1:0] prefix_len;
    } prefix_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic [1:0] s_axis_tuser = OP_INSERT;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    trie_unique_prefix_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predicted trie contents and the context of the word in progress.
    logic [9:0]          trie_child [SLOTS];
    logic [1:0]          trie_count [SLOTS];
    logic [9:0]          trie_last_node;
    logic [9:0]          walk_node;
    logic [5:0]          walk_pos;
    logic [5:0]          uniq_len;
    logic [STATUS_W-1:0] walk_err;

    prefix_result_t expected_results[$];

    int error_count = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int status_tally [8];

    // Sender burst control and the receiver's long hold request.
    int tx_burst_left = 0;
    int tx_gap_max = 3;
    int hold_token = 0;
    int hold_seen = 0;
    int rx_hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_phase = 0;

    // Word under construction and the words inserted since the last clear.
    logic [4:0] word_buf [WORD_MAX];
    logic [4:0] bank_letters [BANK_SIZE][WORD_MAX];
    int         bank_len [BANK_SIZE];
    int         bank_n = 0;
    int         lt_base = 0;
    int         lt_span = 25;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic void trie_wipe();
        for (int i = 0; i < SLOTS; i++)
        begin
            trie_child[i] = '0;
            trie_count[i] = '0;
        end
        trie_last_node = '0;
        walk_node = '0;
        walk_pos = '0;
        uniq_len = '0;
        walk_err = ERR_NONE;
    endfunction

    // Applies one accepted item to the predicted trie; returns 1 when it yields a result.
    function automatic bit trie_apply(input logic [OPCODE_W-1:0] op, input logic [LETTER_W-1:0] raw,
                                      input logic last, output logic [STATUS_W-1:0] st,
                                      output logic [PREFIX_W-1:0] len);
        int unsigned ltr;
        int unsigned slot;
        st = ST_INSERTED;
        len = '0;
        ltr = int'(raw) % ALPH;
        if (op == OP_UNUSED)
            return 1'b0;
        if (op == OP_CLEAR)
        begin
            trie_wipe();
            st = ST_CLEARED;
            return 1'b1;
        end
        if (walk_err == ERR_NONE)
        begin
            if (walk_pos >= MAXLEN)
                walk_err = ST_TOO_LONG;
            else
            begin
                slot = int'(walk_node) * ALPH + ltr;
                if (op == OP_INSERT)
                begin
                    if (trie_child[slot] == '0)
                    begin
                        if (int'(trie_last_node) + 1 >= NODES)
                            walk_err = ST_FULL;
                        else
                        begin
                            trie_last_node = trie_last_node + 1'b1;
                            trie_child[slot] = trie_last_node;
                            trie_count[slot] = 2'd1;
                        end
                    end
                    else if (trie_count[slot] < 2'd2)
                        trie_count[slot] = trie_count[slot] + 1'b1;
                    if (walk_err == ERR_NONE)
                        walk_node = trie_child[slot];
                end
                else if (uniq_len == '0)
                begin
                    // A query stops walking once its unique prefix is known.
                    if (trie_child[slot] == '0)
                        walk_err = ST_ABSENT;
                    else if (trie_count[slot] == 2'd1)
                        uniq_len = walk_pos + 1'b1;
                    else
                        walk_node = trie_child[slot];
                end
                walk_pos = walk_pos + 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        if (walk_err != ERR_NONE)
            st = walk_err;
        else if (op == OP_INSERT)
            st = ST_INSERTED;
        else if (uniq_len != '0)
        begin
            st = ST_FOUND;
            len = uniq_len;
        end
        else
            st = ST_NO_UNIQUE;
        walk_node = '0;
        walk_pos = '0;
        uniq_len = '0;
        walk_err = ERR_NONE;
        return 1'b1;
    endfunction

    // Checks results and feeds accepted items to the predictor, both from pre-edge values.
    always @(posedge clk)
    begin : result_checker
        prefix_result_t want;
        logic [STATUS_W-1:0] st;
        logic [PREFIX_W-1:0] len;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result status %0d length %0d with none pending",
                                              m_axis_tuser, m_axis_tdata[5:0]));
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_axis_tuser, want.status));
                    if (m_axis_tdata[5:0] !== want.prefix_len)
                        report_mismatch($sformatf("prefix length %0d, predicted %0d (status %0d)",
                                                  m_axis_tdata[5:0], want.prefix_len, want.status));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_accepted++;
                if (trie_apply(s_axis_tuser, s_axis_tdata[4:0], s_axis_tlast, st, len))
                begin
                    want.status = st;
                    want.prefix_len = len;
                    expected_results.insert(expected_results.size(), want);
                    status_tally[st]++;
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold when a test asks for one.
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            rx_hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(20, 300);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_phase % 7) < 3);
            endcase
            rx_phase <= rx_phase + 1;
        end
    end

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(input logic [1:0] op, input logic [4:0] ltr, input logic last);
        int gap;
        if (tx_burst_left == 0)
        begin
            tx_burst_left = $urandom_range(1, 32);
            gap = (tx_gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 :
                  $urandom_range(1, tx_gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        tx_burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, ltr};
        s_axis_tlast <= last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_word(input logic [1:0] op, input int len);
        int slot;
        for (int i = 0; i < len; i++)
            send_item(op, word_buf[i], i == len - 1);
        if (op == OP_INSERT)
        begin
            if (bank_n < BANK_SIZE)
            begin
                slot = bank_n;
                bank_n++;
            end
            else
                slot = $urandom_range(0, BANK_SIZE - 1);
            bank_len[slot] = len;
            for (int i = 0; i < len; i++)
                bank_letters[slot][i] = word_buf[i];
        end
    endtask

    // A clear ignores letter and word_end, so both are random.
    task automatic send_clear();
        send_item(OP_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        bank_n = 0;
    endtask

    function automatic logic [4:0] pick_letter();
        if ($urandom_range(0, 99) < 8)
            return 5'($urandom_range(0, 31));
        return 5'(lt_base + $urandom_range(0, lt_span));
    endfunction

    // A narrow letter range makes words share prefixes.
    function automatic void set_letter_range();
        lt_base = $urandom_range(0, 25);
        lt_span = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 3);
    endfunction

    function automatic void make_word(input int len);
        for (int i = 0; i < len; i++)
            word_buf[i] = pick_letter();
    endfunction

    function automatic int random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return $urandom_range(1, 6);
        if (pick < 95)
            return $urandom_range(7, 20);
        return $urandom_range(55, 66);
    endfunction

    function automatic int bank_copy(input int idx);
        for (int i = 0; i < bank_len[idx]; i++)
            word_buf[i] = bank_letters[idx][i];
        return bank_len[idx];
    endfunction

    // Query built from an inserted word: itself, a prefix, an extension or an alias.
    function automatic int query_from_bank();
        int len;
        int extra;
        if (bank_n == 0)
        begin
            set_letter_range();
            len = random_length();
            make_word(len);
            return len;
        end
        len = bank_copy($urandom_range(0, bank_n - 1));
        case ($urandom_range(0, 3))
            0: ;
            1: if (len > 1) len = $urandom_range(1, len - 1);
            2:
            begin
                extra = $urandom_range(1, 3);
                for (int i = 0; i < extra && len < WORD_MAX; i++)
                begin
                    word_buf[len] = pick_letter();
                    len++;
                end
            end
            default:
            begin
                // Letters 26 to 31 land on the same edges as 0 to 5.
                for (int i = 0; i < len; i++)
                    if (word_buf[i] < 5'd6)
                        word_buf[i] = word_buf[i] + 5'd26;
            end
        endcase
        return len;
    endfunction

    // Empty trie, shared and split prefixes, letter extremes, ignored opcode, clears.
    task automatic test_directed();
        tx_gap_max = 3;
        send_item(OP_QUERY, 5'd0, 1'b1);
        send_item(OP_INSERT, 5'd0, 1'b0);
        send_item(OP_INSERT, 5'd1, 1'b0);
        send_item(OP_INSERT, 5'd2, 1'b1);
        send_item(OP_QUERY, 5'd0, 1'b0);
        send_item(OP_QUERY, 5'd1, 1'b0);
        send_item(OP_QUERY, 5'd2, 1'b1);
        send_item(OP_INSERT, 5'd0, 1'b0);
        send_item(OP_INSERT, 5'd1, 1'b0);
        send_item(OP_INSERT, 5'd3, 1'b1);
        send_item(OP_QUERY, 5'd0, 1'b0);
        send_item(OP_QUERY, 5'd1, 1'b0);
        send_item(OP_QUERY, 5'd3, 1'b1);
        // A prefix of two words, with an ignored item in the middle of it.
        send_item(OP_QUERY, 5'd0, 1'b0);
        send_item(OP_UNUSED, 5'd31, 1'b1);
        send_item(OP_QUERY, 5'd1, 1'b1);
        send_item(OP_QUERY, 5'd0, 1'b0);
        send_item(OP_QUERY, 5'd1, 1'b0);
        send_item(OP_QUERY, 5'd25, 1'b1);
        send_item(OP_CLEAR, 5'd31, 1'b0);
        send_item(OP_INSERT, 5'd31, 1'b1);
        send_item(OP_QUERY, 5'd5, 1'b1);
        // Mixed opcodes within one word; the final letter picks the status.
        send_item(OP_INSERT, 5'd25, 1'b0);
        send_item(OP_QUERY, 5'd25, 1'b1);
        send_item(OP_QUERY, 5'd5, 1'b0);
        send_item(OP_INSERT, 5'd7, 1'b1);
        send_clear();
    endtask

    // Words at and beyond the length limit, and an earlier error winning over length.
    task automatic test_too_long();
        send_clear();
        lt_base = 0;
        lt_span = 25;
        make_word(MAXLEN);
        send_word(OP_INSERT, MAXLEN);
        send_word(OP_QUERY, MAXLEN);
        word_buf[MAXLEN] = pick_letter();
        send_word(OP_QUERY, MAXLEN + 1);
        send_word(OP_INSERT, MAXLEN + 1);
        word_buf[0] = 5'((int'(word_buf[0]) % ALPH + 1) % ALPH);
        for (int i = MAXLEN + 1; i < WORD_MAX; i++)
            word_buf[i] = pick_letter();
        send_word(OP_QUERY, WORD_MAX);
        send_clear();
    endtask

    // The receiver holds off while short words keep coming, so the input stalls.
    task automatic test_backpressure();
        int len;
        tx_gap_max = 0;
        hold_token <= hold_token + 1;
        repeat (16)
        begin
            set_letter_range();
            len = $urandom_range(1, 3);
            make_word(len);
            send_word($urandom_range(0, 1) ? OP_QUERY : OP_INSERT, len);
        end
        tx_gap_max = 3;
    endtask

    // Long random words until no node is left, then queries and a repeat insert.
    task automatic test_table_full();
        int len;
        send_clear();
        lt_base = 0;
        lt_span = 25;
        repeat (18)
        begin
            make_word(MAXLEN);
            send_word(OP_INSERT, MAXLEN);
        end
        len = bank_copy(0);
        send_word(OP_INSERT, len);
        repeat (3)
        begin
            len = query_from_bank();
            send_word(OP_QUERY, len);
        end
        send_clear();
    endtask

    // Mostly well-formed inserts and queries, with noise and broken words mixed in.
    task automatic test_random(input int target);
        int done_items;
        int pick;
        int len;
        logic [1:0] op;
        done_items = 0;
        while (done_items < target)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            pick = $urandom_range(0, 999);
            if (pick < 8)
            begin
                send_clear();
                done_items++;
            end
            else if (pick < 480)
            begin
                set_letter_range();
                len = random_length();
                make_word(len);
                send_word(OP_INSERT, len);
                done_items += len;
            end
            else if (pick < 850)
            begin
                len = query_from_bank();
                send_word(OP_QUERY, len);
                done_items += len;
            end
            else if (pick < 900)
                send_item(OP_UNUSED, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            else
            begin
                set_letter_range();
                len = random_length();
                make_word(len);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 59);
                    op = (pick == 0) ? OP_CLEAR : (pick < 4) ? OP_UNUSED :
                         (pick < 32) ? OP_INSERT : OP_QUERY;
                    send_item(op, word_buf[i], i == len - 1 || $urandom_range(0, 9) == 0);
                    if (op != OP_UNUSED)
                        done_items++;
                    if (op == OP_CLEAR)
                        bank_n = 0;
                end
            end
        end
    endtask

    initial
    begin : run_limit
        #RUN_LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int drain;
        foreach (status_tally[i])
            status_tally[i] = 0;
        trie_wipe();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_too_long();
        test_backpressure();
        test_table_full();
        test_random(RANDOM_ITEMS);
        s_axis_tvalid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (16) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_results.size()));
        $display("Covered %0d input transfers and %0d checked results: %0d inserted, %0d found,",
                 items_accepted, results_checked, status_tally[ST_INSERTED],
                 status_tally[ST_FOUND]);
        $display("%0d not unique, %0d absent, %0d too long, %0d table full, %0d clears.",
                 status_tally[ST_NO_UNIQUE], status_tally[ST_ABSENT],
                 status_tally[ST_TOO_LONG], status_tally[ST_FULL], status_tally[ST_CLEARED]);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
